// ===== hdl/vtp_pkg.sv =====
// Package for the vertex transform block: constants and the matrix register type.
// No dependencies.
`default_nettype none
package vtp_pkg;
    localparam int unsigned NUM_REGS = 8;
    localparam logic [31:0] F16_ONE = 32'h0001_0000;
    localparam int unsigned PADDR_W = 6;
    localparam int unsigned QW = 48;
    typedef logic [63:0] mreg_t [NUM_REGS];
    localparam logic [63:0] RESET_VAL [NUM_REGS] = '{
        64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
        64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000};
endpackage
`default_nettype wire

// ===== hdl/vtp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, saturating.
// Depends on vtp_pkg.
`default_nettype none
module vtp_div (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic signed [31:0]  num,
    input  wire logic signed [31:0]  den,
    output logic signed [31:0]       quo
);
    localparam int unsigned W = vtp_pkg::QW;
    logic [W-1:0] n_reg [W+1];
    logic [31:0]  d_reg [W+1];
    logic [W-1:0] r_reg [W+1];
    logic         s_reg [W+1];
    logic [W-1:0] an;
    logic [31:0]  ad;
    logic [W:0]   trial [W];
    logic [W-1:0] nq [W];
    logic [W:0]   mag;
    logic signed [W+1:0] sq;

    always_comb
    begin
        an = num[31] ? W'(-{{16{num[31]}}, num, 16'h0}) : W'({{16{1'b0}}, num, 16'h0});
        ad = den[31] ? 32'(-den) : den;
        for (int i = 0; i < W; i++)
        begin
            trial[i] = {r_reg[i][W-2:0], n_reg[i][W-1-i]} - {{(W-31){1'b0}}, d_reg[i]};
            nq[i] = n_reg[i];
            nq[i][W-1-i] = ~trial[i][W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0] <= an;
            d_reg[0] <= ad;
            r_reg[0] <= '0;
            s_reg[0] <= num[31] ^ den[31];
            for (int i = 0; i < W; i++)
            begin
                n_reg[i+1] <= nq[i];
                d_reg[i+1] <= d_reg[i];
                s_reg[i+1] <= s_reg[i];
                r_reg[i+1] <= trial[i][W] ? {r_reg[i][W-2:0], n_reg[i][W-1-i]}
                                          : trial[i][W-1:0];
            end
        end
    end

    always_comb
    begin
        mag = {1'b0, n_reg[W]};
        sq  = s_reg[W] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        if (sq > $signed((W+2)'(32'h7fff_ffff)))
            quo = 32'sh7fff_ffff;
        else if (sq < -$signed((W+2)'(33'h0_8000_0000)))
            quo = 32'sh8000_0000;
        else
            quo = sq[31:0];
    end
endmodule
`default_nettype wire

// ===== hdl/vertex_transform_perspective_q16.sv =====
// Vertex transform top level: 4x4 Q16.16 matrix by vertex, then perspective divide.
// Depends on vtp_pkg and vtp_div.
//
// Input words (vec_x/y/z) use valid/stall; a word is taken when in_valid is high and
// in_stall low. Result words (out_x/y/z, divided) leave on out_valid/out_stall.
// One word per cycle is accepted back to back while in_stall is low. In order, the
// multiplies are registered as the word is taken, then come the row-sum register, 49
// divider stages (operand register and 48 one-bit stages) and the output register,
// which the selection feeds directly. The whole pipeline advances as one: while
// out_stall is high and a result is held, every stage freezes and in_stall is raised,
// so nothing is lost or repeated. An empty stage freezes as well, so bubbles are
// not closed.
// Reset clears all valid bits and loads the identity matrix. Matrix registers sit
// at byte address 8*i on the APB port and should be written only while idle.
`default_nettype none
module vertex_transform_perspective_q16 (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vtp_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [63:0]                   pwdata,
    output logic [63:0]                        prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [31:0]            vec_x,
    input  wire logic signed [31:0]            vec_y,
    input  wire logic signed [31:0]            vec_z,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [31:0]                 out_x,
    output logic signed [31:0]                 out_y,
    output logic signed [31:0]                 out_z,
    output logic                               divided
);
    localparam int unsigned DL = vtp_pkg::QW;
    localparam int unsigned NV = DL + 3;

    vtp_pkg::mreg_t mtx_reg;
    logic [2:0] ridx;
    logic       en;
    logic [NV-1:0] v_reg;
    logic [31:0] p_reg [4][3];
    logic [31:0] t_reg [4];
    logic [31:0] s_reg [4];
    logic [31:0] sd_reg [DL+1][3];
    logic        dv_reg [DL+1];
    logic signed [31:0] q [3];
    logic        dvs;

    assign pready = 1'b1;
    assign ridx   = paddr[5:3];
    assign prdata = mtx_reg[ridx];
    assign en       = ~(out_valid & out_stall);
    assign in_stall = ~en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mtx_reg <= vtp_pkg::RESET_VAL;
        else if (psel && penable && pwrite && paddr[2:0] == 3'b000)
            mtx_reg[ridx] <= pwdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            v_reg     <= {v_reg[NV-2:0], in_valid};
            out_valid <= v_reg[NV-1];
        end
    end

    function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
        logic signed [63:0] p;
        p = $signed(a) * $signed(b);
        return p[47:16];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 4; r++)
            begin
                p_reg[r][0] <= qmul(mtx_reg[2*r][31:0], vec_x);
                p_reg[r][1] <= qmul(mtx_reg[2*r][63:32], vec_y);
                p_reg[r][2] <= qmul(mtx_reg[2*r+1][31:0], vec_z);
                t_reg[r]    <= mtx_reg[2*r+1][63:32];
                s_reg[r]    <= (p_reg[r][0] + p_reg[r][1]) + (p_reg[r][2] + t_reg[r]);
            end
            for (int c = 0; c < 3; c++)
                sd_reg[0][c] <= s_reg[c];
            dv_reg[0] <= (s_reg[3] != 32'h0) && (s_reg[3] != vtp_pkg::F16_ONE);
            for (int i = 1; i <= DL; i++)
            begin
                sd_reg[i] <= sd_reg[i-1];
                dv_reg[i] <= dv_reg[i-1];
            end
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_div
        vtp_div u_div (
            .clk (clk),
            .en  (en),
            .num (s_reg[c]),
            .den (s_reg[3] == 32'h0 ? 32'sh1 : s_reg[3]),
            .quo (q[c])
        );
    end

    assign dvs = dv_reg[DL];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_x   <= dvs ? q[0] : sd_reg[DL][0];
            out_y   <= dvs ? q[1] : sd_reg[DL][1];
            out_z   <= dvs ? q[2] : sd_reg[DL][2];
            divided <= dvs;
        end
    end
endmodule
`default_nettype wire
